FILE: rtl/core/ptd_pkg.sv
`timescale 1ns / 1ps

package ptd_pkg;

  // default table depth
  localparam int SLOTS_DEF = 16;

  // field widths
  localparam int KIND_W  = 2;
  localparam int NOW_W   = 48;
  localparam int PER_W   = 32;
  localparam int TAG_W   = 16;
  localparam int SLOT_W  = 4;
  localparam int DUR_W   = 32;
  localparam int WAIT_W  = 32;
  localparam int RATIO_W = 24;
  localparam int FRAC_W  = 16;

  // packed stream widths, rounded up to whole bytes
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 64;

  // wait constants
  localparam logic [WAIT_W-1:0] EMPTY_WAIT   = 32'd200;
  localparam logic [WAIT_W-1:0] MIN_WAIT_RST = 32'd10;
  localparam logic [WAIT_W-1:0] MAX_WAIT_RST = 32'd1000;

  // ratio saturation and divider sizing
  localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};
  localparam int INT_W     = RATIO_W - FRAC_W;
  localparam int DIV_CNT_W = $clog2(RATIO_W + 1);

  // configuration register indexes
  localparam logic CFG_MIN_WAIT = 1'b0;
  localparam logic CFG_MAX_WAIT = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    IN_TICK = 2'd0,
    IN_ADD  = 2'd1,
    IN_DONE = 2'd2,
    IN_LOAD = 2'd3
  } in_kind_t;

  typedef enum logic [KIND_W-1:0] {
    RES_FIRE = 2'd0,
    RES_WAIT = 2'd1,
    RES_ADD  = 2'd2,
    RES_LOAD = 2'd3
  } res_kind_t;

  // one slot entry as stored in the table memory
  typedef struct packed {
    logic [PER_W-1:0] period;
    logic [NOW_W-1:0] deadline;
    logic             idle;
    logic [DUR_W-1:0] duration;
    logic [TAG_W-1:0] tag;
  } ptd_entry_t;

  // request to the ratio divider
  typedef struct packed {
    logic             start;
    logic [DUR_W-1:0] dur;
    logic [PER_W-1:0] period;
  } ptd_div_req_t;

  // ratio divider answer
  typedef struct packed {
    logic               done;
    logic [RATIO_W-1:0] ratio;
  } ptd_div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_EVAL,
    S_TICK_FIN,
    S_ADD,
    S_DONE_RD,
    S_DONE_WR,
    S_LOAD_EVAL,
    S_LOAD_DIV,
    S_LOAD_OUT
  } ptd_state_t;

endpackage

FILE: rtl/core/ptd_mem.sv
`timescale 1ns / 1ps

// Slot table: one write port, one read port, registered read data.
module ptd_mem #(
  parameter int DEPTH = ptd_pkg::SLOTS_DEF,
  parameter int AW    = 4
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  ptd_pkg::ptd_entry_t wdata,
  input  logic [AW-1:0]      raddr,
  output ptd_pkg::ptd_entry_t rdata
);

  ptd_pkg::ptd_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/ptd_div.sv
`timescale 1ns / 1ps

// Q8.16 ratio divider: (dur << 16) / period, one quotient bit per cycle,
// saturating. Saturation is caught up front so only 24 bits are iterated.
module ptd_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ptd_pkg::ptd_div_req_t req,
  output ptd_pkg::ptd_div_rsp_t rsp
);

  localparam int PW = ptd_pkg::PER_W;
  localparam int DW = ptd_pkg::DUR_W;
  localparam int RW = ptd_pkg::RATIO_W;
  localparam int SH = ptd_pkg::INT_W;
  localparam int CW = ptd_pkg::DIV_CNT_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW:0]   rem_r, rem_nxt;
  logic [RW-1:0] low_r, low_nxt;
  logic [RW-1:0] q_r, q_nxt;
  logic [PW-1:0] per_r, per_nxt;
  logic [PW:0]   trial;
  logic          sat;

  assign sat   = {{SH{1'b0}}, req.dur} >= {req.period, {SH{1'b0}}};
  assign trial = {rem_r[PW-1:0], low_r[RW-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    per_nxt  = per_r;
    if (req.start) begin
      per_nxt = req.period;
      if (req.period == '0) begin
        q_nxt    = '0;
        done_nxt = 1'b1;
      end else if (sat) begin
        q_nxt    = ptd_pkg::RATIO_MAX;
        done_nxt = 1'b1;
      end else begin
        // high part of the dividend is already below the period
        rem_nxt  = (PW + 1)'(req.dur[DW-1:SH]);
        low_nxt  = {req.dur[SH-1:0], {ptd_pkg::FRAC_W{1'b0}}};
        q_nxt    = '0;
        cnt_nxt  = CW'(RW);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      // restoring step
      if (trial >= {1'b0, per_r}) begin
        rem_nxt = trial - {1'b0, per_r};
        q_nxt   = {q_r[RW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[RW-2:0], 1'b0};
      end
      low_nxt = {low_r[RW-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
    per_r <= per_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.ratio = q_r;

endmodule

FILE: rtl/core/periodic_task_dispatch_table_core.sv
`timescale 1ns / 1ps

// Channel  Ports                     Role
// -------  ------------------------  --------------------------------------
// in       in_tvalid/tready/tdata/   command items (tuser = kind)
//          tuser
// out      out_tvalid/tready/tdata/  result items (tuser = result_kind,
//          tuser/tlast               tlast = last)
// cfg      cfg_we/cfg_idx/cfg_data   min_wait (0), max_wait (1)
//
// One item at a time. Tick: one slot table read per cycle while the scan is not
// stalled. Add: appends a slot at the fill count. Done: read-modify-write. Load
// query: tag scan, then the one-bit-per-cycle ratio divider.
// Reset empties the table through the fill count; no clearing pass.
// A fire item held in the output register stalls the slot scan in place.
module periodic_task_dispatch_table_core #(
  parameter int SLOTS = ptd_pkg::SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: now_ms, period_ms, tag, slot, duration_ms
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ptd_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: kind
  input  logic [ptd_pkg::KIND_W-1:0]       in_tuser,
  // out_tdata: fire_slot, wait_ms, load_ratio, accepted
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ptd_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: result_kind
  output logic [ptd_pkg::KIND_W-1:0]       out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic                             cfg_idx,
  input  logic [ptd_pkg::WAIT_W-1:0]       cfg_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int NW = ptd_pkg::NOW_W;
  localparam int PW = ptd_pkg::PER_W;
  localparam int TW = ptd_pkg::TAG_W;
  localparam int SW = ptd_pkg::SLOT_W;
  localparam int DW = ptd_pkg::DUR_W;
  localparam int WW = ptd_pkg::WAIT_W;
  localparam int RW = ptd_pkg::RATIO_W;
  localparam int KW = ptd_pkg::KIND_W;

  // input field unpacking
  logic [NW-1:0] in_now;
  logic [PW-1:0] in_period;
  logic [TW-1:0] in_tag;
  logic [SW-1:0] in_slot;
  logic [DW-1:0] in_dur;

  assign in_now    = in_tdata[NW-1:0];
  assign in_period = in_tdata[NW+PW-1:NW];
  assign in_tag    = in_tdata[NW+PW+TW-1:NW+PW];
  assign in_slot   = in_tdata[NW+PW+TW+SW-1:NW+PW+TW];
  assign in_dur    = in_tdata[NW+PW+TW+SW+DW-1:NW+PW+TW+SW];

  ptd_pkg::ptd_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt, idx_inc;
  logic [NW-1:0] earliest_r, earliest_nxt;
  logic [RW-1:0] ratio_r, ratio_nxt;
  logic [WW-1:0] min_wait_r, max_wait_r;

  // latched item
  logic [NW-1:0] now_r;
  logic [PW-1:0] period_r;
  logic [TW-1:0] tag_r;
  logic [SW-1:0] slot_r;
  logic [DW-1:0] dur_r;

  // output register
  logic                  out_valid_r;
  ptd_pkg::res_kind_t    out_kind_r;
  logic [SW-1:0]         out_fire_r;
  logic [WW-1:0]         out_wait_r;
  logic [RW-1:0]         out_ratio_r;
  logic                  out_acc_r;
  logic                  out_last_r;
  logic                  out_free;

  // emission request
  logic                  emit;
  ptd_pkg::res_kind_t    e_kind;
  logic [SW-1:0]         e_fire;
  logic [WW-1:0]         e_wait;
  logic [RW-1:0]         e_ratio;
  logic                  e_acc;
  logic                  e_last;

  // memory ports
  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  ptd_pkg::ptd_entry_t   mem_wdata;
  logic [IW-1:0]         mem_raddr;
  ptd_pkg::ptd_entry_t   ent;

  // divider
  ptd_pkg::ptd_div_req_t div_req;
  ptd_pkg::ptd_div_rsp_t div_rsp;

  // helpers
  logic                  accept;
  logic                  due;
  logic [NW-1:0]         new_dl;
  logic                  fire;
  logic [NW-1:0]         gap;
  logic [WW-1:0]         gap_cap;
  logic [WW-1:0]         gap_clamp;
  logic                  add_ok;
  logic [IW+SW-1:0]      idx_slot_ext;
  logic [IW+SW-1:0]      cnt_slot_ext;
  logic [IW+SW-1:0]      slot_addr_ext;
  logic                  slot_occupied;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign idx_inc  = idx_r + CW'(1);

  // slot table and ratio divider
  ptd_mem #(
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (ent)
  );

  ptd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // per-slot tick arithmetic
  assign due    = (ent.deadline < now_r) || (ent.deadline == '0);
  assign new_dl = due ? (now_r + {{(NW-PW){1'b0}}, ent.period}) : ent.deadline;
  assign fire   = due && ent.idle;

  // wait computation from the earliest deadline
  assign gap       = earliest_r - now_r;
  assign gap_cap   = (gap > {{(NW-WW){1'b0}}, max_wait_r}) ? max_wait_r : gap[WW-1:0];
  assign gap_clamp = (gap_cap < min_wait_r) ? min_wait_r : gap_cap;

  // index conversions between table address and 4-bit slot fields
  assign idx_slot_ext  = {{SW{1'b0}}, idx_r[IW-1:0]};
  assign cnt_slot_ext  = {{SW{1'b0}}, count_r[IW-1:0]};
  assign slot_addr_ext = {{IW{1'b0}}, slot_r};
  assign slot_occupied = {{CW{1'b0}}, slot_r} < {{SW{1'b0}}, count_r};
  assign add_ok        = (period_r != '0) && (count_r < CW'(SLOTS));

  // next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    earliest_nxt = earliest_r;
    ratio_nxt    = ratio_r;
    in_tready    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = idx_r[IW-1:0];
    mem_wdata    = ent;
    mem_raddr    = '0;
    div_req      = '0;
    emit         = 1'b0;
    e_kind       = ptd_pkg::RES_FIRE;
    e_fire       = '0;
    e_wait       = '0;
    e_ratio      = '0;
    e_acc        = 1'b0;
    e_last       = 1'b0;

    case (state_r)
      ptd_pkg::S_IDLE: begin
        in_tready = 1'b1;
        idx_nxt   = '0;
        if (accept) begin
          case (ptd_pkg::in_kind_t'(in_tuser))
            ptd_pkg::IN_TICK: begin
              state_nxt = (count_r == '0) ? ptd_pkg::S_TICK_FIN : ptd_pkg::S_TICK_EVAL;
            end
            ptd_pkg::IN_ADD: begin
              state_nxt = ptd_pkg::S_ADD;
            end
            ptd_pkg::IN_DONE: begin
              state_nxt = ptd_pkg::S_DONE_RD;
            end
            ptd_pkg::IN_LOAD: begin
              ratio_nxt = '0;
              state_nxt = (count_r == '0) ? ptd_pkg::S_LOAD_OUT : ptd_pkg::S_LOAD_EVAL;
            end
            default: begin
              state_nxt = ptd_pkg::S_IDLE;
            end
          endcase
        end
      end

      // one slot per cycle; hold while a fire item cannot be placed
      ptd_pkg::S_TICK_EVAL: begin
        mem_raddr = idx_r[IW-1:0];
        if (!fire || out_free) begin
          mem_we             = 1'b1;
          mem_wdata.deadline = new_dl;
          mem_wdata.idle     = ent.idle && !due;
          if (idx_r == '0 || new_dl < earliest_r) begin
            earliest_nxt = new_dl;
          end
          if (fire) begin
            emit   = 1'b1;
            e_kind = ptd_pkg::RES_FIRE;
            e_fire = idx_slot_ext[SW-1:0];
          end
          idx_nxt   = idx_inc;
          mem_raddr = idx_inc[IW-1:0];
          if (idx_inc == count_r) begin
            state_nxt = ptd_pkg::S_TICK_FIN;
          end
        end
      end

      ptd_pkg::S_TICK_FIN: begin
        if (out_free) begin
          emit   = 1'b1;
          e_kind = ptd_pkg::RES_WAIT;
          e_last = 1'b1;
          if (count_r == '0) begin
            e_wait = ptd_pkg::EMPTY_WAIT;
          end else if (now_r > earliest_r) begin
            e_wait = '0;
          end else begin
            e_wait = gap_clamp;
          end
          state_nxt = ptd_pkg::S_IDLE;
        end
      end

      ptd_pkg::S_ADD: begin
        if (out_free) begin
          emit   = 1'b1;
          e_kind = ptd_pkg::RES_ADD;
          e_last = 1'b1;
          if (add_ok) begin
            mem_we             = 1'b1;
            mem_waddr          = count_r[IW-1:0];
            mem_wdata.period   = period_r;
            mem_wdata.deadline = '0;
            mem_wdata.idle     = 1'b1;
            mem_wdata.duration = '0;
            mem_wdata.tag      = tag_r;
            count_nxt          = count_r + CW'(1);
            e_fire             = cnt_slot_ext[SW-1:0];
            e_acc              = 1'b1;
          end
          state_nxt = ptd_pkg::S_IDLE;
        end
      end

      // done: read the slot, then, if occupied, write it back idle with the duration
      ptd_pkg::S_DONE_RD: begin
        mem_raddr = slot_addr_ext[IW-1:0];
        state_nxt = slot_occupied ? ptd_pkg::S_DONE_WR : ptd_pkg::S_IDLE;
      end

      ptd_pkg::S_DONE_WR: begin
        mem_we             = 1'b1;
        mem_waddr          = slot_addr_ext[IW-1:0];
        mem_wdata.idle     = 1'b1;
        mem_wdata.duration = dur_r;
        state_nxt          = ptd_pkg::S_IDLE;
      end

      // first tag match in index order
      ptd_pkg::S_LOAD_EVAL: begin
        mem_raddr = idx_r[IW-1:0];
        if (ent.tag == tag_r) begin
          div_req.start  = 1'b1;
          div_req.dur    = ent.duration;
          div_req.period = ent.period;
          state_nxt      = ptd_pkg::S_LOAD_DIV;
        end else begin
          idx_nxt   = idx_inc;
          mem_raddr = idx_inc[IW-1:0];
          if (idx_inc == count_r) begin
            state_nxt = ptd_pkg::S_LOAD_OUT;
          end
        end
      end

      ptd_pkg::S_LOAD_DIV: begin
        if (div_rsp.done) begin
          ratio_nxt = div_rsp.ratio;
          state_nxt = ptd_pkg::S_LOAD_OUT;
        end
      end

      ptd_pkg::S_LOAD_OUT: begin
        if (out_free) begin
          emit      = 1'b1;
          e_kind    = ptd_pkg::RES_LOAD;
          e_ratio   = ratio_r;
          e_last    = 1'b1;
          state_nxt = ptd_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ptd_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptd_pkg::S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      min_wait_r  <= ptd_pkg::MIN_WAIT_RST;
      max_wait_r  <= ptd_pkg::MAX_WAIT_RST;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          ptd_pkg::CFG_MIN_WAIT: min_wait_r <= cfg_data;
          ptd_pkg::CFG_MAX_WAIT: max_wait_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    earliest_r <= earliest_nxt;
    ratio_r    <= ratio_nxt;
    if (accept) begin
      now_r    <= in_now;
      period_r <= in_period;
      tag_r    <= in_tag;
      slot_r   <= in_slot;
      dur_r    <= in_dur;
    end
    if (emit) begin
      out_kind_r  <= e_kind;
      out_fire_r  <= e_fire;
      out_wait_r  <= e_wait;
      out_ratio_r <= e_ratio;
      out_acc_r   <= e_acc;
      out_last_r  <= e_last;
    end
  end

  // output packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = KW'(out_kind_r);
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(ptd_pkg::OUT_DATA_W - SW - WW - RW - 1){1'b0}},
                       out_acc_r, out_ratio_r, out_wait_r, out_fire_r};

endmodule
